// ===== src/avh_pkg.sv =====
// Shared types and constants for the arc voltage height control block.
package avh_pkg;

    // Configuration write port
    localparam int CFG_DATA_W = 16;
    localparam int HYST_W     = 6;
    localparam int STAB_W     = 16;

    typedef enum logic [1:0] {
        REG_SET_POINT = 2'd0,
        REG_ON_HYST   = 2'd1,
        REG_OFF_HYST  = 2'd2,
        REG_STABILIZE = 2'd3
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam int SET_POINT_RST = 100;
    localparam logic [HYST_W-1:0] ON_HYST_RST  = 6'd3;
    localparam logic [HYST_W-1:0] OFF_HYST_RST = 6'd1;
    localparam logic [STAB_W-1:0] STAB_RST     = 16'd500;

    // Timers
    localparam int DOWN_W     = 8;
    localparam int SETTLE_W   = 16;
    localparam int PIERCE_W   = 32;
    localparam logic [DOWN_W-1:0] KERF_TIMEOUT_MS = 8'd7;
    localparam int KERF_RISE = 1;

    // Discrete inputs of one tick
    typedef struct packed {
        logic torch_on;
        logic arc_good;
        logic arc_changed;
    } tick_flags_t;

    // Status flags of the controller after a tick
    typedef struct packed {
        logic drive_up;
        logic drive_down;
        logic relay_on;
        logic control_active;
        logic kerf_active;
    } ctrl_status_t;

endpackage

// ===== src/avh_cfg_regs.sv =====
// Configuration register file of the height controller.
module avh_cfg_regs
    import avh_pkg::*;
#(
    parameter int VOLT_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic [VOLT_BITS-1:0]  set_point,
    output logic [HYST_W-1:0]     on_hyst,
    output logic [HYST_W-1:0]     off_hyst,
    output logic [STAB_W-1:0]     stabilize
);

    logic [VOLT_BITS-1:0] set_point_reg;
    logic [HYST_W-1:0]    on_hyst_reg;
    logic [HYST_W-1:0]    off_hyst_reg;
    logic [STAB_W-1:0]    stabilize_reg;

    // Register writes, one per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_point_reg <= VOLT_BITS'(SET_POINT_RST);
            on_hyst_reg   <= ON_HYST_RST;
            off_hyst_reg  <= OFF_HYST_RST;
            stabilize_reg <= STAB_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SET_POINT: set_point_reg <= cfg_wdata[VOLT_BITS-1:0];
                REG_ON_HYST:   on_hyst_reg   <= cfg_wdata[HYST_W-1:0];
                REG_OFF_HYST:  off_hyst_reg  <= cfg_wdata[HYST_W-1:0];
                REG_STABILIZE: stabilize_reg <= cfg_wdata[STAB_W-1:0];
            endcase
        end
    end

    assign set_point = set_point_reg;
    assign on_hyst   = on_hyst_reg;
    assign off_hyst  = off_hyst_reg;
    assign stabilize = stabilize_reg;

endmodule

// ===== src/avh_ctrl.sv =====
// Height control state, pierce counter and per-tick update logic.
module avh_ctrl
    import avh_pkg::*;
#(
    parameter int VOLT_BITS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  tick_flags_t          flags,
    input  logic [VOLT_BITS-1:0] voltage,
    input  logic [VOLT_BITS-1:0] set_point,
    input  logic [HYST_W-1:0]    on_hyst,
    input  logic [HYST_W-1:0]    off_hyst,
    input  logic [STAB_W-1:0]    stabilize,
    output ctrl_status_t         status,
    output logic [PIERCE_W-1:0]  pierce_total
);

    // Signed width that holds set point +/- hysteresis without wrapping
    localparam int SW = VOLT_BITS + 2;

    logic                 cutting_reg,  cutting_next;
    logic                 up_reg,       up_next;
    logic                 down_reg,     down_next;
    logic                 kerf_reg,     kerf_next;
    logic                 control_reg,  control_next;
    logic [VOLT_BITS-1:0] kref_reg,     kref_next;
    logic [DOWN_W-1:0]    down_t_reg,   down_t_next;
    logic [SETTLE_W-1:0]  settle_reg,   settle_next;
    logic [PIERCE_W-1:0]  pierce_reg,   pierce_next;

    logic signed [SW-1:0] v_s, kr_s, up_on, up_off, dn_on, dn_off;
    logic [SETTLE_W-1:0]  settle_base;
    logic [DOWN_W-1:0]    down_base;
    logic                 down_start;

    assign v_s    = signed'(SW'(voltage));
    assign kr_s   = signed'(SW'(kref_reg));
    assign up_off = signed'(SW'(set_point)) - signed'(SW'(off_hyst));
    assign up_on  = signed'(SW'(set_point)) - signed'(SW'(on_hyst));
    assign dn_off = signed'(SW'(set_point)) + signed'(SW'(off_hyst));
    assign dn_on  = signed'(SW'(set_point)) + signed'(SW'(on_hyst));

    // Next state for one tick
    always_comb begin
        cutting_next = cutting_reg;
        up_next      = up_reg;
        down_next    = down_reg;
        kerf_next    = kerf_reg;
        control_next = control_reg;
        kref_next    = kref_reg;
        pierce_next  = pierce_reg;
        down_start   = 1'b0;
        // rising torch-on starts a cut and restarts the stabilize count
        settle_base  = (!cutting_reg && flags.torch_on) ? '0 : settle_reg;

        if (cutting_reg || flags.torch_on) begin
            cutting_next = 1'b1;
            if (flags.arc_changed && flags.arc_good) begin
                pierce_next = pierce_reg + 1'b1;
            end
            priority if (!flags.torch_on) begin
                up_next      = 1'b0;
                down_next    = 1'b0;
                kerf_next    = 1'b0;
                control_next = 1'b0;
                cutting_next = 1'b0;
            end else if (!flags.arc_good) begin
                up_next      = 1'b0;
                down_next    = 1'b0;
                kerf_next    = 1'b0;
                control_next = 1'b0;
            end else if (!control_reg) begin
                if (kerf_reg) begin
                    // resume once voltage falls back to the kerf reference
                    if (kr_s >= v_s) begin
                        kerf_next    = 1'b0;
                        control_next = 1'b1;
                    end
                end else if (settle_base > stabilize) begin
                    control_next = 1'b1;
                end
            end else begin
                // voltage regulation with on/off hysteresis
                priority if (up_reg) begin
                    if (v_s >= up_off) begin
                        up_next   = 1'b0;
                        down_next = 1'b0;
                    end
                end else if (down_reg) begin
                    priority if (v_s <= dn_off) begin
                        up_next   = 1'b0;
                        down_next = 1'b0;
                    end else if (v_s > kr_s + SW'(KERF_RISE) ||
                                 (down_t_reg > KERF_TIMEOUT_MS && v_s >= kr_s)) begin
                        // kerf crossing: suspend control
                        up_next      = 1'b0;
                        down_next    = 1'b0;
                        kerf_next    = 1'b1;
                        control_next = 1'b0;
                    end else begin
                        down_next = 1'b1;
                    end
                end else if (v_s <= up_on) begin
                    up_next   = 1'b1;
                    down_next = 1'b0;
                end else if (v_s >= dn_on && !kerf_reg) begin
                    up_next    = 1'b0;
                    down_next  = 1'b1;
                    kref_next  = voltage;
                    down_start = 1'b1;
                end else begin
                    up_next = 1'b0;
                end
            end
        end

        // both timers advance (saturating) at the end of every tick
        down_base   = down_start ? '0 : down_t_reg;
        down_t_next = (down_base == '1) ? down_base : down_base + 1'b1;
        settle_next = (settle_base == '1) ? settle_base : settle_base + 1'b1;
    end

    // State registers, updated once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutting_reg <= 1'b0;
            up_reg      <= 1'b0;
            down_reg    <= 1'b0;
            kerf_reg    <= 1'b0;
            control_reg <= 1'b0;
            kref_reg    <= '0;
            down_t_reg  <= '0;
            settle_reg  <= '0;
            pierce_reg  <= '0;
        end else if (adv) begin
            cutting_reg <= cutting_next;
            up_reg      <= up_next;
            down_reg    <= down_next;
            kerf_reg    <= kerf_next;
            control_reg <= control_next;
            kref_reg    <= kref_next;
            down_t_reg  <= down_t_next;
            settle_reg  <= settle_next;
            pierce_reg  <= pierce_next;
        end
    end

    assign status.drive_up       = up_reg;
    assign status.drive_down     = down_reg;
    assign status.relay_on       = cutting_reg;
    assign status.control_active = control_reg;
    assign status.kerf_active    = kerf_reg;
    assign pierce_total          = pierce_reg;

endmodule

// ===== src/arc_voltage_height_control.sv =====
// A tick passes through the input register, then the state/result register, before its result is valid.
// Throughput: one tick per cycle; a new tick is taken while a result waits, stalls follow m_ready.
// The result fields are the controller state registers, held until the result transfer.
// Reset (aresetn low, synchronous): idle, all flags and timers cleared, pierce count zero,
// configuration back to set point 100, hysteresis 3 / 1, stabilize 500 ms.
module arc_voltage_height_control
    import avh_pkg::*;
#(
    parameter int VOLT_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // tick input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_torch_on,
    input  logic                  s_arc_good,
    input  logic                  s_arc_changed,
    input  logic [VOLT_BITS-1:0]  s_arc_voltage,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_drive_up,
    output logic                  m_drive_down,
    output logic                  m_relay_on,
    output logic                  m_control_active,
    output logic                  m_kerf_active,
    output logic [PIERCE_W-1:0]   m_pierce_total
);

    logic                 in_valid_reg;
    tick_flags_t          flags_reg;
    logic [VOLT_BITS-1:0] volt_reg;
    logic                 out_valid_reg;
    logic                 adv;

    logic [VOLT_BITS-1:0] set_point;
    logic [HYST_W-1:0]    on_hyst;
    logic [HYST_W-1:0]    off_hyst;
    logic [STAB_W-1:0]    stabilize;
    ctrl_status_t         status;

    // Tick moves into the result stage when that stage is free or draining
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            flags_reg <= '{torch_on: s_torch_on, arc_good: s_arc_good,
                           arc_changed: s_arc_changed};
            volt_reg  <= s_arc_voltage;
        end
    end

    // Result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    avh_cfg_regs #(
        .VOLT_BITS (VOLT_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index_t'(cfg_index)),
        .cfg_wdata (cfg_wdata),
        .set_point (set_point),
        .on_hyst   (on_hyst),
        .off_hyst  (off_hyst),
        .stabilize (stabilize)
    );

    avh_ctrl #(
        .VOLT_BITS (VOLT_BITS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .flags        (flags_reg),
        .voltage      (volt_reg),
        .set_point    (set_point),
        .on_hyst      (on_hyst),
        .off_hyst     (off_hyst),
        .stabilize    (stabilize),
        .status       (status),
        .pierce_total (m_pierce_total)
    );

    assign m_valid          = out_valid_reg;
    assign m_drive_up       = status.drive_up;
    assign m_drive_down     = status.drive_down;
    assign m_relay_on       = status.relay_on;
    assign m_control_active = status.control_active;
    assign m_kerf_active    = status.kerf_active;

endmodule

// ===== src/avh_checker.sv =====
// Port-level assertions for the height controller and their bind.
module avh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_drive_up,
    input logic        m_drive_down,
    input logic        m_relay_on,
    input logic        m_control_active,
    input logic        m_kerf_active,
    input logic [31:0] m_pierce_total
);

    // Never drive both directions
    a_drive_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_drive_up && m_drive_down))
        else $error("drive up and down both active");

    // Drive only while the control loop runs
    a_drive_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_drive_up || m_drive_down)) |-> m_control_active)
        else $error("drive active without control");

    // Outside a cut everything is off
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_relay_on) |->
            !(m_drive_up || m_drive_down || m_control_active || m_kerf_active))
        else $error("activity while relay off");

    // Kerf hold and control loop exclude each other
    a_kerf_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_control_active && m_kerf_active))
        else $error("kerf and control both active");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pierce_total)))
        else $error("stalled result changed");

endmodule

bind arc_voltage_height_control avh_checker u_avh_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_drive_up       (m_drive_up),
    .m_drive_down     (m_drive_down),
    .m_relay_on       (m_relay_on),
    .m_control_active (m_control_active),
    .m_kerf_active    (m_kerf_active),
    .m_pierce_total   (m_pierce_total)
);

// ===== sim/tb_arc_voltage_height_control.sv =====
// Self-checking testbench for the arc voltage torch height controller.
`timescale 1ns / 100ps

module tb_arc_voltage_height_control;
    import avh_pkg::*;

    localparam int VOLT_BITS          = 10;
    localparam int VOLT_MAX           = (1 << VOLT_BITS) - 1;
    localparam int KERF_TIMEOUT_TICKS = 7;
    localparam int KERF_RISE_V        = 1;
    localparam int IDLE_PCT           = 29;
    localparam int HOLD_CYCLES        = 60;
    localparam int CYCLE_LIMIT        = 200000;

    // Expected status word of one tick
    typedef struct packed {
        ctrl_status_t           flags;
        logic [PIERCE_W-1:0]    pierces;
    } tick_status_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_torch_on;
    logic                  s_arc_good;
    logic                  s_arc_changed;
    logic [VOLT_BITS-1:0]  s_arc_voltage;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_drive_up;
    logic                  m_drive_down;
    logic                  m_relay_on;
    logic                  m_control_active;
    logic                  m_kerf_active;
    logic [PIERCE_W-1:0]   m_pierce_total;

    // Controller model: configuration shadow and state
    logic [VOLT_BITS-1:0]  set_point;
    logic [5:0]            on_hyst;
    logic [5:0]            off_hyst;
    logic [15:0]           stab_ms;
    logic                  cutting_q;
    logic                  up_q;
    logic                  down_q;
    logic                  kerf_q;
    logic                  control_q;
    logic [VOLT_BITS-1:0]  kerf_ref;
    logic [7:0]            down_ms;
    logic [15:0]           settle_ms;
    logic [PIERCE_W-1:0]   pierces;

    tick_status_t          pending_status[$];
    int                    mismatch_count;
    int                    ticks_sent;
    int                    status_checked;
    int                    settings_count;
    int                    kerf_entries;
    int                    cycle_count;
    bit                    steady;
    bit                    hold_request;

    arc_voltage_height_control #(
        .VOLT_BITS(VOLT_BITS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_torch_on      (s_torch_on),
        .s_arc_good      (s_arc_good),
        .s_arc_changed   (s_arc_changed),
        .s_arc_voltage   (s_arc_voltage),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_up      (m_drive_up),
        .m_drive_down    (m_drive_down),
        .m_relay_on      (m_relay_on),
        .m_control_active(m_control_active),
        .m_kerf_active   (m_kerf_active),
        .m_pierce_total  (m_pierce_total)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: run limit of %0d cycles reached, %0d status words still due",
                 $time, CYCLE_LIMIT, pending_status.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Advance the controller by one tick and queue the status it should report
    function automatic void advance_controller(input logic torch, input logic arc,
                                               input logic changed,
                                               input logic [VOLT_BITS-1:0] volts);
        int v;
        int sp;
        int onh;
        int offh;
        int kr;
        tick_status_t st;
        v    = int'(volts);
        sp   = int'(set_point);
        onh  = int'(on_hyst);
        offh = int'(off_hyst);
        kr   = int'(kerf_ref);

        // rising torch-on starts a cut and restarts the settle timer
        if (!cutting_q && torch) begin
            cutting_q = 1'b1;
            settle_ms = '0;
        end
        if (cutting_q) begin
            if (changed && arc)
                pierces = pierces + 1'b1;
            if (!torch || !arc) begin
                {up_q, down_q, kerf_q, control_q} = '0;
                if (!torch)
                    cutting_q = 1'b0;
            end else if (!control_q) begin
                // resume after kerf once voltage falls back, else wait out settle time
                if (kerf_q) begin
                    if (kr >= v) begin
                        kerf_q    = 1'b0;
                        control_q = 1'b1;
                    end
                end else if (settle_ms > stab_ms) begin
                    control_q = 1'b1;
                end
            end else if (up_q) begin
                if (v >= sp - offh)
                    {up_q, down_q} = 2'b00;
            end else if (down_q) begin
                if (v <= sp + offh) begin
                    {up_q, down_q} = 2'b00;
                end else if (v > kr + KERF_RISE_V ||
                             (int'(down_ms) > KERF_TIMEOUT_TICKS && v >= kr)) begin
                    // kerf crossing: stop and suspend control
                    {up_q, down_q} = 2'b00;
                    kerf_q    = 1'b1;
                    control_q = 1'b0;
                    kerf_entries++;
                end
            end else if (v <= sp - onh) begin
                {up_q, down_q} = 2'b10;
            end else if (v >= sp + onh && !kerf_q) begin
                {up_q, down_q} = 2'b01;
                kerf_ref = volts;
                down_ms  = '0;
            end
        end

        // timers saturate
        if (down_ms != 8'hFF)
            down_ms++;
        if (settle_ms != 16'hFFFF)
            settle_ms++;

        st.flags.drive_up       = up_q;
        st.flags.drive_down     = down_q;
        st.flags.relay_on       = cutting_q;
        st.flags.control_active = control_q;
        st.flags.kerf_active    = kerf_q;
        st.pierces              = pierces;
        pending_status.push_back(st);
    endfunction

    // Send one tick; returns at the edge where the transfer happened
    task automatic send_tick(input logic torch, input logic arc, input logic changed,
                             input logic [VOLT_BITS-1:0] volts);
        int gap;
        // each offered cycle is idle with the same odds
        gap = 0;
        if (!steady)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_torch_on    <= torch;
        s_arc_good    <= arc;
        s_arc_changed <= changed;
        s_arc_voltage <= volts;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        advance_controller(torch, arc, changed, volts);
        ticks_sent++;
    endtask

    // Stop offering ticks and let every due status word come out
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SET_POINT: set_point = data[VOLT_BITS-1:0];
            REG_ON_HYST:   on_hyst   = data[5:0];
            REG_OFF_HYST:  off_hyst  = data[5:0];
            REG_STABILIZE: stab_ms   = data[15:0];
            default: ;
        endcase
    endtask

    // Load all four registers; unused upper data bits carry junk
    task automatic configure(input int sp, input int onh, input int offh, input int stab);
        wait_idle();
        write_reg(REG_SET_POINT, {6'($urandom), 10'(sp)});
        write_reg(REG_ON_HYST, {10'($urandom), 6'(onh)});
        write_reg(REG_OFF_HYST, {10'($urandom), 6'(offh)});
        write_reg(REG_STABILIZE, 16'(stab));
        settings_count++;
    endtask

    // One cut: idle lead-in, torch on, arc strike, voltage wander around
    // the set point with occasional arc loss and noise ticks, torch off
    task automatic run_cut(input int cut_ticks);
        int  level;
        int  i;
        bit  arc_now;
        bit  arc_next;
        repeat ($urandom_range(0, 2))
            send_tick(1'b0, 1'($urandom), 1'($urandom), VOLT_BITS'($urandom));
        arc_now = 1'b0;
        repeat ($urandom_range(0, 2))
            send_tick(1'b1, 1'b0, 1'b0, VOLT_BITS'($urandom));
        level = int'(set_point) + int'($urandom_range(0, 40)) - 20;
        for (i = 0; i < cut_ticks; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: level += int'($urandom_range(0, 6)) - 3;
                6, 7: ;  // hold, lets the kerf timeout run out
                8: level = int'(set_point) + int'($urandom_range(0, 2 * on_hyst + 8))
                           - int'(on_hyst) - 4;
                default: level += int'($urandom_range(0, 3));  // climb as at a kerf
            endcase
            if (level < 0)
                level = 0;
            if (level > VOLT_MAX)
                level = VOLT_MAX;
            arc_next = arc_now;
            if (!arc_now && (i == 0 || $urandom_range(0, 3) == 0))
                arc_next = 1'b1;
            else if (arc_now && $urandom_range(0, 99) < 3)
                arc_next = 1'b0;
            if ($urandom_range(0, 99) < 8)
                send_tick(1'($urandom), 1'($urandom), 1'($urandom), VOLT_BITS'($urandom));
            else
                send_tick(1'b1, arc_next, arc_next != arc_now, VOLT_BITS'(level));
            arc_now = arc_next;
        end
        send_tick(1'b0, arc_now, 1'b0, VOLT_BITS'(level));
    endtask

    task automatic run_cuts(input int n_ticks, input int min_len, input int max_len);
        int target;
        target = ticks_sent + n_ticks;
        while (ticks_sent < target)
            run_cut($urandom_range(min_len, max_len));
    endtask

    // Directed walk: idle ticks, entry, pierce counting, up and down moves,
    // kerf by rise and by timeout, kerf resume, arc loss, torch off
    task automatic test_directed_sequence();
        logic [12:0] script [0:24];
        int i;
        script = '{
            {3'b000, 10'd0},    {3'b011, 10'd1023}, {3'b100, 10'd100}, {3'b111, 10'd100},
            {3'b110, 10'd100},  {3'b110, 10'd100},  {3'b110, 10'd90},  {3'b110, 10'd99},
            {3'b110, 10'd110},  {3'b110, 10'd112},  {3'b110, 10'd115}, {3'b110, 10'd108},
            {3'b110, 10'd104},  {3'b110, 10'd104},  {3'b110, 10'd104}, {3'b110, 10'd104},
            {3'b110, 10'd104},  {3'b110, 10'd104},  {3'b110, 10'd104}, {3'b110, 10'd104},
            {3'b110, 10'd104},  {3'b101, 10'd104},  {3'b011, 10'd0},   {3'b111, 10'd1023},
            {3'b000, 10'd512}
        };
        configure(100, 3, 1, 2);
        for (i = 0; i < 25; i++)
            send_tick(script[i][12], script[i][11], script[i][10], script[i][9:0]);
    endtask

    task automatic test_nominal_cuts();
        repeat (4) begin
            configure($urandom_range(60, 200), 3, 1, $urandom_range(0, 10));
            run_cuts(110, 20, 60);
        end
    endtask

    task automatic test_top_set_point();
        configure(VOLT_MAX, 63, 63, 0);
        run_cuts(250, 20, 60);
    endtask

    // Zero hysteresis and zero set point, both channels never idle
    task automatic test_zero_hysteresis();
        configure(0, 0, 0, 0);
        steady = 1'b1;
        run_cuts(250, 20, 60);
        steady = 1'b0;
    endtask

    // Settle time that a cut never reaches
    task automatic test_long_stabilize();
        configure(500, 5, 2, 65535);
        run_cuts(150, 30, 80);
    endtask

    // Receiver holds off while ticks keep coming, so the block stalls its input
    task automatic test_output_backpressure();
        configure($urandom_range(50, 900), $urandom_range(1, 10), $urandom_range(0, 5),
                  $urandom_range(0, 8));
        repeat (3) begin
            hold_request = 1'b1;
            run_cuts(80, 10, 40);
        end
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            configure($urandom_range(0, VOLT_MAX), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom_range(0, 15));
            run_cuts(80, 10, 50);
        end
    endtask

    // Receiver: random stalls, optional long hold-off
    initial begin
        int hold_left;
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Check each status transfer against the oldest expectation
    always @(posedge aclk) begin
        tick_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                mismatch_count++;
                $display("%0t: status transfer with nothing expected, expected none, actual %b",
                         $time, {m_drive_up, m_drive_down, m_relay_on, m_control_active,
                                 m_kerf_active});
            end else begin
                want = pending_status.pop_front();
                status_checked++;
                compare_field("drive_up", 32'(want.flags.drive_up), 32'(m_drive_up));
                compare_field("drive_down", 32'(want.flags.drive_down), 32'(m_drive_down));
                compare_field("relay_on", 32'(want.flags.relay_on), 32'(m_relay_on));
                compare_field("control_active", 32'(want.flags.control_active),
                              32'(m_control_active));
                compare_field("kerf_active", 32'(want.flags.kerf_active),
                              32'(m_kerf_active));
                compare_field("pierce_total", want.pierces, m_pierce_total);
            end
        end
    end

    initial begin
        // known levels on every input
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_SET_POINT;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_torch_on    = 1'b0;
        s_arc_good    = 1'b0;
        s_arc_changed = 1'b0;
        s_arc_voltage = '0;
        steady        = 1'b0;
        hold_request  = 1'b0;

        // model state after reset
        set_point      = 10'd100;
        on_hyst        = 6'd3;
        off_hyst       = 6'd1;
        stab_ms        = 16'd500;
        {cutting_q, up_q, down_q, kerf_q, control_q} = '0;
        kerf_ref       = '0;
        down_ms        = '0;
        settle_ms      = '0;
        pierces        = '0;
        mismatch_count = 0;
        ticks_sent     = 0;
        status_checked = 0;
        settings_count = 0;
        kerf_entries   = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_sequence();
        test_nominal_cuts();
        test_top_set_point();
        test_zero_hysteresis();
        test_long_stabilize();
        test_output_backpressure();
        test_random_settings();
        wait_idle();

        $display("Ran %0d ticks under %0d register settings; %0d status words checked.",
                 ticks_sent, settings_count, status_checked);
        $display("Cuts produced %0d pierces and %0d kerf crossings.", pierces, kerf_entries);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
